### rtl/core/ccfd_pkg.sv
package ccfd_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [7:0]  CODE_FULL     = 8'hFF;
  localparam logic [7:0]  LEN_MAX       = 8'hFF;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd4;
  localparam logic [1:0]  HOLD_FULL     = 2'd2;
  localparam int unsigned CRC_STEPS     = 8;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_BADCRC = 2'd1,
    VERDICT_SHORT  = 2'd2,
    VERDICT_CODING = 2'd3
  } verdict_e;

  // one queue entry: an optional payload byte followed by an optional verdict
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       has_verdict;
    verdict_e   verdict;
  } ccfd_rec_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < CRC_STEPS; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/ccfd_front.sv
module ccfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_end_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output ccfd_pkg::ccfd_rec_t  q_rec_o
);
  import ccfd_pkg::*;

  logic [7:0]  min_len_q;
  logic [7:0]  cnt_q, cnt_d;
  logic        owed_q, owed_d;
  logic        err_q, err_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic        accept;
  logic        dec_valid;
  logic [7:0]  dec_byte;
  ccfd_rec_t   rec;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_rec_o    = rec;
  assign q_push_o   = accept && (rec.has_byte || rec.has_verdict);

  always_comb begin
    cnt_d      = cnt_q;
    owed_d     = owed_q;
    err_d      = err_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    crc_d      = crc_q;
    len_d      = len_q;
    dec_valid  = 1'b0;
    dec_byte   = data_byte_i;
    rec        = '{has_byte: 1'b0, data: 8'h00, has_verdict: 1'b0, verdict: VERDICT_OK};
    if (accept) begin
      if (len_q != LEN_MAX) len_d = len_q + 8'd1;
      if (cnt_q == 8'd0) begin
        // code byte: release the zero owed by the previous block
        dec_valid = owed_q;
        dec_byte  = 8'h00;
        if (data_byte_i == 8'h00) begin
          err_d  = 1'b1;
          owed_d = 1'b0;
        end else begin
          cnt_d  = data_byte_i - 8'd1;
          owed_d = (data_byte_i != CODE_FULL);
        end
      end else begin
        if (data_byte_i == 8'h00) err_d = 1'b1;
        dec_valid = 1'b1;
        cnt_d     = cnt_q - 8'd1;
      end
      if (dec_valid) begin
        if (held_cnt_q != HOLD_FULL) begin
          if (held_cnt_q[0]) held1_d = dec_byte;
          else held0_d = dec_byte;
          held_cnt_d = held_cnt_q + 2'd1;
        end else begin
          rec.has_byte = 1'b1;
          rec.data     = held0_q;
          held0_d      = held1_q;
          held1_d      = dec_byte;
          crc_d        = crc_update(crc_q, held0_q);
        end
      end
      if (frame_end_i) begin
        rec.has_verdict = 1'b1;
        if (len_d < min_len_q) begin
          rec.verdict = VERDICT_SHORT;
        end else if (err_d || cnt_d != 8'd0 || held_cnt_d != HOLD_FULL) begin
          rec.verdict = VERDICT_CODING;
        end else if ({held1_d, held0_d} == (crc_d ^ CRC_INIT)) begin
          rec.verdict = VERDICT_OK;
        end else begin
          rec.verdict = VERDICT_BADCRC;
        end
        cnt_d      = 8'd0;
        owed_d     = 1'b0;
        err_d      = 1'b0;
        held_cnt_d = 2'd0;
        crc_d      = CRC_INIT;
        len_d      = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= MIN_LEN_RESET;
      cnt_q      <= 8'd0;
      owed_q     <= 1'b0;
      err_q      <= 1'b0;
      held_cnt_q <= 2'd0;
      crc_q      <= CRC_INIT;
      len_q      <= 8'd0;
    end else begin
      if (cfg_we_i) min_len_q <= cfg_wdata_i;
      cnt_q      <= cnt_d;
      owed_q     <= owed_d;
      err_q      <= err_d;
      held_cnt_q <= held_cnt_d;
      crc_q      <= crc_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("hold count out of range");

endmodule

### rtl/core/ccfd_queue.sv
module ccfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ccfd_pkg::ccfd_rec_t  push_rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output ccfd_pkg::ccfd_rec_t  pop_rec_o,
  output logic                 empty_o
);
  import ccfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ccfd_rec_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  assign full_o    = (cnt_q == FULL_CNT);
  assign empty_o   = (cnt_q == '0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    if (pop_i)  rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

### rtl/core/ccfd_back.sv
module ccfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccfd_pkg::ccfd_rec_t  rec_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 is_verdict_o,
  output logic [1:0]           verdict_o,
  output logic                 last_o
);
  import ccfd_pkg::*;

  logic       valid_q, valid_d;
  logic       phase_q, phase_d;   // payload part of the head entry already sent
  logic       load;
  logic [7:0] byte_q, byte_d;
  logic       isv_q, isv_d;
  verdict_e   verdict_q, verdict_d;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d   = valid_q;
    phase_d   = phase_q;
    byte_d    = byte_q;
    isv_d     = isv_q;
    verdict_d = verdict_q;
    pop_o     = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (rec_i.has_byte && !phase_q) begin
          byte_d    = rec_i.data;
          isv_d     = 1'b0;
          verdict_d = VERDICT_OK;
          pop_o     = !rec_i.has_verdict;
          phase_d   = rec_i.has_verdict;
        end else begin
          byte_d    = 8'h00;
          isv_d     = 1'b1;
          verdict_d = rec_i.verdict;
          pop_o     = 1'b1;
          phase_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    isv_q     <= isv_d;
    verdict_q <= verdict_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign is_verdict_o = isv_q;
  assign verdict_o    = verdict_q;
  assign last_o       = isv_q;

  a_phase_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !empty_i)
    else $error("split entry lost from queue");

endmodule

### rtl/core/cobs_crc_frame_decoder.sv
// Result path: each result item is written into the entry queue, then loaded into the output register.
// Throughput: one input item per cycle while in_stall_o is low; one result item per cycle leaves the
// output register while out_stall_i is low. A frame end byte that also releases a payload byte yields
// two results, payload byte then verdict; the entry queue (QUEUE_DEPTH deep) absorbs that while input keeps flowing.
// Reset (rst_ni low, async): frame state cleared, CRC at 0xFFFF, min length back to 4, queue empty.
module cobs_crc_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_verdict_o,
  output logic [1:0] verdict_o,
  output logic       last_o
);
  import ccfd_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  ccfd_rec_t push_rec, head_rec;

  ccfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (push_rec)
  );

  ccfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_rec_o  (head_rec),
    .empty_o    (q_empty)
  );

  ccfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (head_rec),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_verdict_o (is_verdict_o),
    .verdict_o    (verdict_o),
    .last_o       (last_o)
  );

endmodule

### tb/cobs_crc_frame_decoder_test.sv
module cobs_crc_frame_decoder_test;
  import ccfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_verdict;
    verdict_e   verdict;
    logic       last;
  } frame_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       is_verdict_o;
  logic [1:0] verdict_o;
  logic       last_o;

  cobs_crc_frame_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_verdict_o (is_verdict_o),
    .verdict_o    (verdict_o),
    .last_o       (last_o)
  );

  // stimulus and expectations
  enc_item_t     tx_bytes[$];
  frame_result_t decoded_due[$];
  octet_t        raw_q[$];
  octet_t        enc_q[$];
  int unsigned   bytes_queued;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  bit            in_taken;
  enc_item_t     next_byte;

  // decoder state mirror
  logic [7:0]  min_len;
  logic [7:0]  blk_left;
  logic        zero_due;
  logic [7:0]  held [2];
  logic [1:0]  held_n;
  logic [15:0] crc_acc;
  logic [7:0]  enc_len;
  logic        bad_coding;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] x25_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[k]) c = (c >> 1) ^ CRC_POLY_REFL;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic octet_t random_octet();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return 8'h00;
    if (pick < 30) return 8'hFF;
    return octet_t'($urandom);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic frame_restart();
    blk_left   = '0;
    zero_due   = 1'b0;
    held[0]    = '0;
    held[1]    = '0;
    held_n     = '0;
    crc_acc    = CRC_INIT;
    enc_len    = '0;
    bad_coding = 1'b0;
  endtask

  // the two newest decoded bytes stay held; the oldest one leaves as payload
  task automatic hold_push(input logic [7:0] b);
    frame_result_t r;
    if (held_n < HOLD_FULL) begin
      held[held_n] = b;
      held_n++;
    end else begin
      r = '{out_byte: held[0], is_verdict: 1'b0, verdict: VERDICT_OK, last: 1'b0};
      crc_acc = x25_step(crc_acc, held[0]);
      held[0] = held[1];
      held[1] = b;
      decoded_due.push_back(r);
    end
  endtask

  task automatic cobs_decode_byte(input logic [7:0] b, input logic fe);
    frame_result_t r;
    if (enc_len != LEN_MAX) enc_len++;
    if (blk_left == 0) begin
      if (zero_due) hold_push(8'h00);
      if (b == 8'h00) begin
        bad_coding = 1'b1;
        zero_due   = 1'b0;
      end else begin
        blk_left = b - 8'd1;
        zero_due = (b != CODE_FULL);
      end
    end else begin
      if (b == 8'h00) bad_coding = 1'b1;
      hold_push(b);
      blk_left--;
    end
    if (fe) begin
      r.out_byte   = 8'h00;
      r.is_verdict = 1'b1;
      r.last       = 1'b1;
      // owed zero at frame end is simply dropped
      if (enc_len < min_len) r.verdict = VERDICT_SHORT;
      else if (bad_coding || blk_left != 0 || held_n < HOLD_FULL) r.verdict = VERDICT_CODING;
      else if ({held[1], held[0]} == ~crc_acc) r.verdict = VERDICT_OK;
      else r.verdict = VERDICT_BADCRC;
      decoded_due.push_back(r);
      frame_restart();
    end
  endtask

  // append the checksum to raw_q and stuff the result into enc_q
  task automatic seal_payload(input bit bad_crc);
    logic [15:0] sum;
    logic [15:0] flip;
    int          code_at;
    logic [7:0]  code;
    sum = CRC_INIT;
    foreach (raw_q[i]) sum = x25_step(sum, raw_q[i]);
    sum = ~sum;
    if (bad_crc) begin
      flip = 16'($urandom_range(16'hFFFF, 1));
      sum  = sum ^ flip;
    end
    raw_q.push_back(sum[7:0]);
    raw_q.push_back(sum[15:8]);
    enc_q.delete();
    code_at = 0;
    enc_q.push_back(8'h00);
    code = 8'd1;
    foreach (raw_q[i]) begin
      if (raw_q[i] == 8'h00) begin
        enc_q[code_at] = code;
        code_at = enc_q.size();
        enc_q.push_back(8'h00);
        code = 8'd1;
      end else begin
        enc_q.push_back(raw_q[i]);
        code++;
        if (code == CODE_FULL) begin
          enc_q[code_at] = code;
          code_at = enc_q.size();
          enc_q.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    enc_q[code_at] = code;
  endtask

  task automatic send_encoded();
    enc_item_t it;
    foreach (enc_q[i]) begin
      it.data      = enc_q[i];
      it.frame_end = (i == enc_q.size() - 1);
      tx_bytes.push_back(it);
    end
    bytes_queued += enc_q.size();
    enc_q.delete();
  endtask

  task automatic random_frame(input int unsigned max_payload);
    int unsigned kind;
    int unsigned n;
    raw_q.delete();
    n = $urandom_range(max_payload);
    repeat (n) raw_q.push_back(random_octet());
    kind = $urandom_range(99);
    if (kind < 10) begin
      // line noise
      enc_q.delete();
      repeat ($urandom_range(8, 1)) enc_q.push_back(octet_t'($urandom));
    end else begin
      seal_payload(kind < 20);
      if (kind >= 20 && kind < 28) begin
        enc_q.insert($urandom_range(enc_q.size() - 1), 8'h00);
      end else if (kind >= 28 && kind < 36) begin
        repeat ($urandom_range(2, 1)) enc_q.pop_back();
      end else if (kind >= 36 && kind < 42) begin
        enc_q[0] = 8'h00;
      end
    end
    if (enc_q.size() == 0) enc_q.push_back(octet_t'($urandom));
    send_encoded();
  endtask

  task automatic random_run(input int unsigned target, input int unsigned max_payload);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < target) random_frame(max_payload);
  endtask

  // wait until every byte went in and every result came out
  task automatic settle();
    do @(posedge clk_i);
    while (tx_bytes.size() != 0 || in_valid_i || decoded_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_len(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    min_len = v;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = tx_bytes.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_byte.data;
          frame_end_i <= next_byte.frame_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: check results, then predict from the accepted input item
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_due.size() == 0) begin
          $error("unexpected result item: out_byte %0h is_verdict %0b verdict %0d last %0b",
                 out_byte_o, is_verdict_o, verdict_o, last_o);
          mismatch_count++;
        end else begin
          want = decoded_due.pop_front();
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("is_verdict", 8'(want.is_verdict), 8'(is_verdict_o));
          check_field("verdict", 8'(want.verdict), 8'(verdict_o));
          check_field("last", 8'(want.last), 8'(last_o));
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) cobs_decode_byte(data_byte_i, frame_end_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL cobs_crc_frame_decoder");
      $finish;
    end
  end

  initial begin
    frame_restart();
    min_len        = MIN_LEN_RESET;
    bytes_queued   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    in_taken       = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    frame_end_i    = 1'b0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 8'h00;
    send_idle_pct  = 28;
    recv_idle_pct  = 63;
    rst_ni         = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset minimum length
    raw_q = '{8'h00, 8'hFF};
    seal_payload(1'b0);
    send_encoded();
    enc_q = '{8'h01};                       // too short
    send_encoded();
    enc_q = '{8'h00, 8'h02, 8'h33, 8'h01};  // zero code byte
    send_encoded();
    enc_q = '{8'h04, 8'h12, 8'h00, 8'h34};  // zero inside a block
    send_encoded();
    enc_q = '{8'h06, 8'hAA, 8'hBB, 8'hCC};  // block cut off by frame end
    send_encoded();
    raw_q = '{8'h80};
    seal_payload(1'b1);
    send_encoded();
    settle();

    write_min_len(8'd1);
    enc_q = '{8'h01};                       // nothing decoded
    send_encoded();
    enc_q = '{8'h02, 8'h55};                // one decoded byte, no checksum
    send_encoded();
    raw_q.delete();                         // empty payload, good checksum
    seal_payload(1'b0);
    send_encoded();
    random_run(100, 12);
    settle();

    send_idle_pct = 63;
    recv_idle_pct = 28;
    write_min_len(8'd255);
    // long frame: full 0xFF blocks and a saturated length count
    raw_q.delete();
    repeat (260) raw_q.push_back(octet_t'($urandom_range(255, 1)));
    repeat (8) raw_q.push_back(random_octet());
    seal_payload(1'b0);
    send_encoded();
    random_run(40, 12);
    settle();

    write_min_len(8'd0);
    random_run(100, 12);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_len(8'd7);
    random_run(100, 12);
    settle();

    write_min_len(MIN_LEN_RESET);
    random_run(60, 8);
    settle();

    if (mismatch_count == 0) begin
      $display("PASS cobs_crc_frame_decoder");
    end else begin
      $display("FAIL cobs_crc_frame_decoder");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ccfd_pkg.sv
rtl/core/ccfd_front.sv
rtl/core/ccfd_queue.sv
rtl/core/ccfd_back.sv
rtl/core/cobs_crc_frame_decoder.sv
tb/cobs_crc_frame_decoder_test.sv
